// ===== rtl/fls_pkg.sv =====
// fls_pkg: shared constants, codes and state type of the free list slot allocator
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package fls_pkg;

    // table geometry
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int COUNT_W = IDX_W + 1;

    // highest slot index
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

    // payload widths of the channels
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;

    // end of list marker: any link or head at or above it means empty
    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(ENTRIES);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REORDER = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_TAIL
    } state_t;

endpackage

// ===== rtl/fls_in_if.sv =====
// fls_in_if: request channel of the allocator (valid, ready, operation and slot)
// depends on fls_pkg for payload widths
`timescale 1ns / 1ps

interface fls_in_if;

    logic                        valid;
    logic                        ready;
    logic [fls_pkg::FUNC_W-1:0]  func;
    logic [fls_pkg::SLOT_W-1:0]  slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);

endinterface

// ===== rtl/fls_out_if.sv =====
// fls_out_if: response channel of the allocator (valid, ready, grant, status, count)
// depends on fls_pkg for payload widths
`timescale 1ns / 1ps

interface fls_out_if;

    logic                          valid;
    logic                          ready;
    logic [fls_pkg::SLOT_W-1:0]    granted_index;
    logic [fls_pkg::STATUS_W-1:0]  status;
    logic [fls_pkg::COUNT_W-1:0]   used_count;

    modport source (output valid, output granted_index, output status,
                    output used_count, input ready);
    modport sink   (input valid, input granted_index, input status,
                    input used_count, output ready);

endinterface

// ===== rtl/free_list_slot_allocator.sv =====
// free_list_slot_allocator: linked free list over a table of slots, with link and
// free-mark memories; depends on fls_pkg, fls_in_if and fls_out_if
`timescale 1ns / 1ps

// channel  | dir | handshake    | payload
// ---------+-----+--------------+------------------------------------------
// req      | in  | valid/ready  | func, slot_index
// rsp      | out | valid/ready  | granted_index, status, used_count
//
// allocate, free and unused codes pass through accept (memory read issued)
// and then commit (read-modify-write of the link and free-mark memories)
// reorder reads the free mark of each slot in turn, then writes the tail link
// after reset a clearing pass writes link i+1 and a free mark
// to every slot; req.ready stays low until it ends
// a held result in the output register stalls the commit of the next item only

module free_list_slot_allocator (
    input  logic      clk,
    input  logic      rst_n,
    fls_in_if.sink    req,
    fls_out_if.source rsp
);

    // control state
    fls_pkg::state_t state_reg, state_next;
    logic [fls_pkg::LINK_W-1:0]  head_reg, head_next;
    logic [fls_pkg::COUNT_W-1:0] in_use_reg, in_use_next;
    logic [fls_pkg::IDX_W-1:0]   scan_reg, scan_next;
    logic [fls_pkg::IDX_W-1:0]   last_reg, last_next;
    logic                        have_last_reg, have_last_next;
    logic                        out_valid_reg, out_valid_next;

    // item and result payload
    logic [fls_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [fls_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [fls_pkg::SLOT_W-1:0]   granted_reg, granted_next;
    logic [fls_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fls_pkg::COUNT_W-1:0]  used_reg, used_next;

    // link memory
    logic [fls_pkg::LINK_W-1:0] link_mem [fls_pkg::ENTRIES];
    logic                        link_re;
    logic [fls_pkg::IDX_W-1:0]   link_raddr;
    logic [fls_pkg::LINK_W-1:0]  link_rdata_reg;
    logic                        link_we;
    logic [fls_pkg::IDX_W-1:0]   link_waddr;
    logic [fls_pkg::LINK_W-1:0]  link_wdata;
    logic [fls_pkg::LINK_W-1:0]  link_rd;

    // free-mark memory
    logic                        free_mem [fls_pkg::ENTRIES];
    logic                        free_re;
    logic [fls_pkg::IDX_W-1:0]   free_raddr;
    logic                        free_rdata_reg;
    logic                        free_we;
    logic [fls_pkg::IDX_W-1:0]   free_waddr;
    logic                        free_wdata;
    logic                        free_rd;

    logic accept;
    logic out_free;

    // handshakes
    assign req.ready         = (state_reg == fls_pkg::ST_IDLE);
    assign accept            = req.valid && req.ready;
    assign out_free          = !out_valid_reg || rsp.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.status        = status_reg;
    assign rsp.used_count    = used_reg;

    // registered read data
    assign link_rd = link_rdata_reg;
    assign free_rd = free_rdata_reg;

    // link memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    // free-mark memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        if (free_re)
        begin
            free_rdata_reg <= free_mem[free_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fls_pkg::ST_INIT:
            begin
                if (scan_reg == fls_pkg::LAST_SLOT)
                begin
                    state_next = fls_pkg::ST_IDLE;
                end
            end
            fls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.func == fls_pkg::FUNC_REORDER) ? fls_pkg::ST_WALK
                                                                     : fls_pkg::ST_EXEC;
                end
            end
            fls_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = fls_pkg::ST_IDLE;
                end
            end
            fls_pkg::ST_WALK:
            begin
                if (scan_reg == fls_pkg::LAST_SLOT)
                begin
                    state_next = fls_pkg::ST_TAIL;
                end
            end
            fls_pkg::ST_TAIL:
            begin
                state_next = fls_pkg::ST_EXEC;
            end
            default:
            begin
                state_next = fls_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next      = head_reg;
        in_use_next    = in_use_reg;
        scan_next      = scan_reg;
        last_next      = last_reg;
        have_last_next = have_last_reg;
        func_next      = func_reg;
        slot_next      = slot_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        link_re        = 1'b0;
        link_raddr     = head_reg[fls_pkg::IDX_W-1:0];
        link_we        = 1'b0;
        link_waddr     = last_reg;
        link_wdata     = fls_pkg::LIST_END;
        free_re        = 1'b0;
        free_raddr     = fls_pkg::IDX_W'(req.slot_index);
        free_we        = 1'b0;
        free_waddr     = fls_pkg::IDX_W'(slot_reg);
        free_wdata     = 1'b1;

        // result taken downstream
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fls_pkg::ST_INIT:
            begin
                // clearing pass: slot i links to i+1 and is free
                link_we    = 1'b1;
                link_waddr = scan_reg;
                link_wdata = {1'b0, scan_reg} + fls_pkg::LINK_W'(1);
                free_we    = 1'b1;
                free_waddr = scan_reg;
                free_wdata = 1'b1;
                scan_next  = scan_reg + fls_pkg::IDX_W'(1);
            end
            fls_pkg::ST_IDLE:
            begin
                // latch the item and read both memories
                if (accept)
                begin
                    func_next = req.func;
                    slot_next = req.slot_index;
                    link_re   = 1'b1;
                    free_re   = 1'b1;
                    if (req.func == fls_pkg::FUNC_REORDER)
                    begin
                        free_raddr     = '0;
                        scan_next      = '0;
                        have_last_next = 1'b0;
                        head_next      = fls_pkg::LIST_END;
                    end
                end
            end
            fls_pkg::ST_WALK:
            begin
                // chain each free slot behind the previous one
                if (free_rd)
                begin
                    if (have_last_reg)
                    begin
                        link_we    = 1'b1;
                        link_waddr = last_reg;
                        link_wdata = {1'b0, scan_reg};
                    end
                    else
                    begin
                        head_next = {1'b0, scan_reg};
                    end
                    last_next      = scan_reg;
                    have_last_next = 1'b1;
                end
                if (scan_reg != fls_pkg::LAST_SLOT)
                begin
                    scan_next  = scan_reg + fls_pkg::IDX_W'(1);
                    free_re    = 1'b1;
                    free_raddr = scan_reg + fls_pkg::IDX_W'(1);
                end
            end
            fls_pkg::ST_TAIL:
            begin
                // terminate the rebuilt list
                if (have_last_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = last_reg;
                    link_wdata = fls_pkg::LIST_END;
                end
            end
            fls_pkg::ST_EXEC:
            begin
                // commit and load the result once the output register is free
                if (out_free)
                begin
                    granted_next   = '0;
                    status_next    = fls_pkg::STAT_OK;
                    out_valid_next = 1'b1;
                    case (func_reg)
                        fls_pkg::FUNC_ALLOC:
                        begin
                            if (head_reg >= fls_pkg::LIST_END)
                            begin
                                status_next = fls_pkg::STAT_FULL;
                            end
                            else
                            begin
                                granted_next = fls_pkg::SLOT_W'(head_reg[fls_pkg::IDX_W-1:0]);
                                head_next    = link_rd;
                                free_we      = 1'b1;
                                free_waddr   = head_reg[fls_pkg::IDX_W-1:0];
                                free_wdata   = 1'b0;
                                in_use_next  = in_use_reg + fls_pkg::COUNT_W'(1);
                            end
                        end
                        fls_pkg::FUNC_FREE:
                        begin
                            if (({1'b0, slot_reg} >= fls_pkg::LIST_END) || free_rd)
                            begin
                                status_next = fls_pkg::STAT_DOUBLE;
                            end
                            else
                            begin
                                free_we    = 1'b1;
                                free_waddr = fls_pkg::IDX_W'(slot_reg);
                                free_wdata = 1'b1;
                                link_we    = 1'b1;
                                link_waddr = fls_pkg::IDX_W'(slot_reg);
                                link_wdata = head_reg;
                                head_next  = {1'b0, slot_reg};
                                if (in_use_reg != '0)
                                begin
                                    in_use_next = in_use_reg - fls_pkg::COUNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = fls_pkg::STAT_OK;
                        end
                    endcase
                    used_next = in_use_next;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fls_pkg::ST_INIT;
            head_reg      <= '0;
            in_use_reg    <= '0;
            scan_reg      <= '0;
            last_reg      <= '0;
            have_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            in_use_reg    <= in_use_next;
            scan_reg      <= scan_next;
            last_reg      <= last_next;
            have_last_reg <= have_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        slot_reg    <= slot_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
        used_reg    <= used_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= fls_pkg::COUNT_W'(fls_pkg::ENTRIES))
        else $error("used count beyond table size");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= fls_pkg::LIST_END)
        else $error("free head beyond end marker");

    a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == fls_pkg::STAT_FULL)
            |-> (granted_reg == '0 && used_reg == fls_pkg::COUNT_W'(fls_pkg::ENTRIES)))
        else $error("full reported while slots remain");

    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fls_pkg::ST_WALK && scan_reg != fls_pkg::LAST_SLOT)
            |=> (state_reg == fls_pkg::ST_WALK
                 && scan_reg == $past(scan_reg) + fls_pkg::IDX_W'(1)))
        else $error("reorder walk skipped a slot");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for free_list_slot_allocator; drives requests, predicts
// each response from its own free list model and compares them field by field
// depends on fls_pkg, fls_in_if, fls_out_if and the free_list_slot_allocator rtl
`timescale 1ns / 1ps

module tb;

    import fls_pkg::*;

    // func code that the block treats as a no-op
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1450;
    // model copies: one replayed while building stimulus, one on accepted items
    localparam int GEN_COPY = 1;
    localparam int CHK_COPY = 0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic              hold;
        logic [6:0]        send_idle;
        logic [6:0]        recv_stall;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  used;
    } response_t;

    logic clk = 1'b0;
    logic rst_n;

    fls_in_if  req_ch ();
    fls_out_if rsp_ch ();

    free_list_slot_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // free list model state, one set per copy
    logic [LINK_W-1:0]  chain_link   [0:1][0:ENTRIES-1];
    logic               slot_is_free [0:1][0:ENTRIES-1];
    logic [LINK_W-1:0]  list_head    [0:1];
    logic [COUNT_W-1:0] alloc_count  [0:1];

    request_t  request_q[$];
    response_t expected_rsp_q[$];

    int       failures = 0;
    logic     req_fire = 1'b0;
    int       recv_stall_now = 0;
    int       gen_send_idle = 0;
    int       gen_recv_stall = 0;
    int       random_done = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_free_list(input int cp);
        for (int i = 0; i < ENTRIES; i++)
        begin
            chain_link[cp][i]   = LINK_W'(i + 1);
            slot_is_free[cp][i] = 1'b1;
        end
        list_head[cp]   = '0;
        alloc_count[cp] = '0;
    endfunction

    // one operation on the free list, returns the response it must produce
    function automatic response_t apply_request(input int cp, input logic [FUNC_W-1:0] func,
                                                input logic [SLOT_W-1:0] slot);
        response_t        r;
        logic [LINK_W-1:0] tail;
        r.granted = '0;
        r.status  = STAT_OK;
        case (func)
            FUNC_ALLOC:
            begin
                if (list_head[cp] >= LIST_END)
                    r.status = STAT_FULL;
                else
                begin
                    r.granted = list_head[cp][SLOT_W-1:0];
                    list_head[cp] = chain_link[cp][r.granted];
                    slot_is_free[cp][r.granted] = 1'b0;
                    alloc_count[cp] = alloc_count[cp] + COUNT_W'(1);
                end
            end
            FUNC_FREE:
            begin
                if (LINK_W'(slot) >= LIST_END || slot_is_free[cp][slot])
                    r.status = STAT_DOUBLE;
                else
                begin
                    slot_is_free[cp][slot] = 1'b1;
                    chain_link[cp][slot] = list_head[cp];
                    list_head[cp] = LINK_W'(slot);
                    if (alloc_count[cp] != '0)
                        alloc_count[cp] = alloc_count[cp] - COUNT_W'(1);
                end
            end
            FUNC_REORDER:
            begin
                // relink free slots in ascending order
                tail = LIST_END;
                list_head[cp] = LIST_END;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_is_free[cp][i])
                    begin
                        if (tail == LIST_END)
                            list_head[cp] = LINK_W'(i);
                        else
                            chain_link[cp][tail] = LINK_W'(i);
                        tail = LINK_W'(i);
                    end
                end
                if (tail != LIST_END)
                    chain_link[cp][tail] = LIST_END;
            end
            default: ;
        endcase
        r.used = alloc_count[cp];
        return r;
    endfunction

    // random slot that is free (or allocated) in the stimulus copy
    function automatic logic [SLOT_W-1:0] pick_slot(input logic want_free);
        int hits;
        int k;
        hits = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_is_free[GEN_COPY][i] == want_free)
                hits++;
        if (hits == 0)
            return SLOT_W'($urandom_range(ENTRIES - 1));
        k = $urandom_range(hits - 1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_is_free[GEN_COPY][i] == want_free)
            begin
                if (k == 0)
                    return SLOT_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                                 input logic hold);
        request_t it;
        it.func       = func;
        it.slot       = slot;
        it.hold       = hold;
        it.send_idle  = 7'(gen_send_idle);
        it.recv_stall = 7'(gen_recv_stall);
        void'(apply_request(GEN_COPY, func, slot));
        request_q.push_back(it);
    endtask

    // idling levels for a segment of random items
    task automatic set_idling(input int phase);
        if ($urandom_range(3) == 0)
        begin
            gen_send_idle  = 0;
            gen_recv_stall = 0;
        end
        else
        begin
            case (phase)
                0: begin gen_send_idle = 0;  gen_recv_stall = 0;  end
                1: begin gen_send_idle = 83; gen_recv_stall = 0;  end
                2: begin gen_send_idle = 0;  gen_recv_stall = 83; end
                default: begin gen_send_idle = 22; gen_recv_stall = 22; end
            endcase
        end
    endtask

    task automatic build_directed();
        queue_request(FUNC_ALLOC, 8'h00, 1'b0);
        queue_request(FUNC_ALLOC, 8'hFF, 1'b0);
        queue_request(FUNC_ALLOC, 8'h00, 1'b0);
        queue_request(FUNC_FREE, 8'd1, 1'b0);
        // double free, and free of a slot never handed out
        queue_request(FUNC_FREE, 8'd1, 1'b0);
        queue_request(FUNC_FREE, 8'hFF, 1'b0);
        queue_request(FUNC_UNUSED, 8'hFF, 1'b0);
        queue_request(FUNC_REORDER, 8'hAA, 1'b0);
        queue_request(FUNC_ALLOC, 8'h55, 1'b0);
        queue_request(FUNC_ALLOC, 8'h00, 1'b0);
        queue_request(FUNC_FREE, 8'd0, 1'b0);
        queue_request(FUNC_FREE, 8'd2, 1'b0);
        queue_request(FUNC_FREE, 8'd0, 1'b0);
        queue_request(FUNC_UNUSED, 8'h00, 1'b0);
        queue_request(FUNC_REORDER, 8'h00, 1'b0);
        queue_request(FUNC_ALLOC, 8'h00, 1'b0);
        queue_request(FUNC_FREE, 8'hAA, 1'b0);
        queue_request(FUNC_FREE, 8'h55, 1'b0);
        queue_request(FUNC_ALLOC, 8'h00, 1'b0);
        queue_request(FUNC_FREE, pick_slot(1'b0), 1'b0);
    endtask

    task automatic build_random();
        int kind;
        int seg_len;
        int alloc_bias;
        int r;
        int phase;
        int last_phase;
        logic hold;
        last_phase = -1;
        while (random_done < RANDOM_ITEMS)
        begin
            phase = (random_done * 4) / RANDOM_ITEMS;
            set_idling(phase);
            // pause for a drained block at the first segment of each phase and now and then
            hold = (phase != last_phase) || ($urandom_range(9) == 0);
            last_phase = phase;
            kind = $urandom_range(15);
            if (kind == 0)
            begin
                // fill the table, then run into full
                while (alloc_count[GEN_COPY] < ENTRIES)
                begin
                    queue_request(FUNC_ALLOC, SLOT_W'($urandom), hold);
                    hold = 1'b0;
                    random_done++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    queue_request(FUNC_ALLOC, SLOT_W'($urandom), 1'b0);
                    random_done++;
                end
            end
            else if (kind == 1)
            begin
                // release every allocated slot in random order
                while (alloc_count[GEN_COPY] != 0)
                begin
                    queue_request(FUNC_FREE, pick_slot(1'b0), hold);
                    hold = 1'b0;
                    random_done++;
                end
                queue_request(FUNC_FREE, pick_slot(1'b1), 1'b0);
                queue_request(FUNC_ALLOC, SLOT_W'($urandom), 1'b0);
                random_done += 2;
            end
            else
            begin
                seg_len = $urandom_range(10, 60);
                alloc_bias = $urandom_range(20, 80);
                repeat (seg_len)
                begin
                    r = $urandom_range(99);
                    if (r < 3)
                        queue_request(FUNC_REORDER, SLOT_W'($urandom), hold);
                    else if (r < 5)
                        queue_request(FUNC_UNUSED, SLOT_W'($urandom), hold);
                    else if (r < 9)
                        queue_request(FUNC_FREE, SLOT_W'($urandom), hold);
                    else if (r < 12)
                        queue_request(FUNC_FREE, pick_slot(1'b1), hold);
                    else if ($urandom_range(99) < alloc_bias)
                        queue_request(FUNC_ALLOC, SLOT_W'($urandom), hold);
                    else
                        queue_request(FUNC_FREE, pick_slot(1'b0), hold);
                    hold = 1'b0;
                    random_done++;
                end
            end
        end
    endtask

    // request driver: payload changes on the falling edge
    always @(negedge clk)
    begin
        logic show;
        if (rst_n)
        begin
            if (request_q.size() != 0)
                recv_stall_now = request_q[0].recv_stall;
            if (req_ch.valid && !req_fire)
                show = 1'b1;
            else if (request_q.size() == 0)
                show = 1'b0;
            else if (request_q[0].hold && expected_rsp_q.size() != 0)
                show = 1'b0;
            else
                show = ($urandom_range(99) >= request_q[0].send_idle);
            req_ch.valid <= show;
            if (show)
            begin
                req_ch.func       <= request_q[0].func;
                req_ch.slot_index <= request_q[0].slot;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_now);
        end
    end

    // monitor: predicts on accepted requests, checks accepted responses
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n)
        begin
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
            begin
                void'(request_q.pop_front());
                expected_rsp_q.push_back(apply_request(CHK_COPY, req_ch.func,
                                                       req_ch.slot_index));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response granted %0d status %0d used %0d",
                             $time, rsp_ch.granted_index, rsp_ch.status, rsp_ch.used_count);
                    failures++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_ch.granted_index !== want.granted)
                    begin
                        $display("%0t: granted_index expected %0d actual %0d",
                                 $time, want.granted, rsp_ch.granted_index);
                        failures++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        failures++;
                    end
                    if (rsp_ch.used_count !== want.used)
                    begin
                        $display("%0t: used_count expected %0d actual %0d",
                                 $time, want.used, rsp_ch.used_count);
                        failures++;
                    end
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_ALLOC;
        req_ch.slot_index = '0;
        rsp_ch.ready      = 1'b0;
        reset_free_list(CHK_COPY);
        reset_free_list(GEN_COPY);
        build_directed();
        build_random();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        while (request_q.size() != 0 || req_ch.valid)
            @(negedge clk);
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
        // a late extra response would show up here
        repeat (ENTRIES + 40) @(negedge clk);
        if (failures == 0)
            $display("free_list_slot_allocator verification clean");
        else
            $display("free_list_slot_allocator verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("free_list_slot_allocator verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fls_pkg.sv
rtl/fls_in_if.sv
rtl/fls_out_if.sv
rtl/free_list_slot_allocator.sv
test/tb.sv
